/* sv/pi_position_controller_macros.svh */
// Assertion macros shared by the pi_position_controller RTL.
`ifndef PI_POSITION_CONTROLLER_MACROS_SVH
`define PI_POSITION_CONTROLLER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PIPC_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("pipc assertion failed");

// Next-cycle implication, checked outside reset.
`define PIPC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("pipc assertion failed");

`endif

/* sv/pipc_pkg.sv */
// Constants and types of the PI position controller.
package pipc_pkg;

    localparam int SUM_WIDTH  = 24;
    localparam int SAMPLE_W   = 8;
    localparam int GAIN_W     = 8;
    localparam int FRAC_W     = 8;
    localparam int LIMIT_W    = 10;
    localparam int DRIVE_W    = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 16;

    localparam int ERR_W   = SAMPLE_W + 1;
    localparam int IPROD_W = SUM_WIDTH + GAIN_W + 1;
    localparam int IQ_W    = IPROD_W - FRAC_W;
    localparam int PPROD_W = GAIN_W + 1 + ERR_W;
    localparam int PQ_W    = PPROD_W - FRAC_W;
    localparam int ITERM_W = LIMIT_W + 1;
    localparam int TOT_W   = ITERM_W + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SETPOINT       = 3'd0,
        REG_KP_GAIN        = 3'd1,
        REG_KI_GAIN        = 3'd2,
        REG_INTEGRAL_LIMIT = 3'd3,
        REG_OUTPUT_LIMIT   = 3'd4,
        REG_DEADBAND       = 3'd5,
        REG_VALID_LOW      = 3'd6,
        REG_VALID_HIGH     = 3'd7
    } cfg_index_t;

    localparam logic [SAMPLE_W-1:0] RST_SETPOINT       = 8'd128;
    localparam logic [GAIN_W-1:0]   RST_KP_GAIN        = 8'd77;
    localparam logic [GAIN_W-1:0]   RST_KI_GAIN        = 8'd51;
    localparam logic [LIMIT_W-1:0]  RST_INTEGRAL_LIMIT = 10'd100;
    localparam logic [LIMIT_W-1:0]  RST_OUTPUT_LIMIT   = 10'd300;
    localparam logic [SAMPLE_W-1:0] RST_DEADBAND       = 8'd2;
    localparam logic [SAMPLE_W-1:0] RST_VALID_LOW      = 8'd20;
    localparam logic [SAMPLE_W-1:0] RST_VALID_HIGH     = 8'd250;

endpackage

/* sv/pi_position_controller.sv */
// PI position controller: one camera sample in, one clamped drive value out.
//
//  channel   direction  ports                         payload
//  -------   ---------  ----------------------------  ---------------------------
//  s_        in         s_tvalid s_tready s_tdata     sample (8b unsigned)
//  m_        out        m_tvalid m_tready m_tdata     drive (11b signed), zero-fill
//  cfg_      in         cfg_we cfg_index cfg_wdata    register write, no read-back
//
//  One sample per cycle while m_tready is high: the input register holds the
//  sample, the accumulator and the drive value are formed from it, and the
//  drive lands in the output register.
//  The cycle time is set by the ki x accumulator multiply feeding the clamps.
//  aresetn (synchronous, active low) loads the register defaults and clears
//  the accumulator and both valid flags.
//  When m_tready is low a full output register holds; the input register still
//  takes one more transfer, then s_tready drops until the output drains.
`include "pi_position_controller_macros.svh"

module pi_position_controller
    import pipc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // input samples
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,    // [7:0] sample
    // drive results
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata     // [10:0] drive, [15:11] zero
);

    // configuration registers
    logic [SAMPLE_W-1:0] setpoint_reg;
    logic [GAIN_W-1:0]   kp_gain_reg;
    logic [GAIN_W-1:0]   ki_gain_reg;
    logic [LIMIT_W-1:0]  integral_limit_reg;
    logic [LIMIT_W-1:0]  output_limit_reg;
    logic [SAMPLE_W-1:0] deadband_reg;
    logic [SAMPLE_W-1:0] valid_low_reg;
    logic [SAMPLE_W-1:0] valid_high_reg;

    // pipeline registers
    logic                        s1_valid_reg;
    logic [SAMPLE_W-1:0]         sample_reg;
    logic signed [SUM_WIDTH-1:0] error_sum_reg;
    logic signed [SUM_WIDTH-1:0] error_sum_next;
    logic                        m_valid_reg;
    logic signed [DRIVE_W-1:0]   drive_reg;
    logic signed [DRIVE_W-1:0]   drive_next;

    logic advance;
    logic s1_fire;
    logic s_fire;

    // datapath intermediates
    logic signed [ERR_W-1:0]     err;
    logic signed [SUM_WIDTH:0]   sum_wide;
    logic signed [SUM_WIDTH-1:0] sum_sat;
    logic signed [GAIN_W:0]      ki_s;
    logic signed [GAIN_W:0]      kp_s;
    logic signed [IPROD_W-1:0]   iprod;
    logic signed [IPROD_W-1:0]   iprod_adj;
    logic signed [IQ_W-1:0]      iq;
    logic signed [IQ_W-1:0]      ilim_ext;
    logic signed [ITERM_W-1:0]   iterm;
    logic signed [PPROD_W-1:0]   pprod;
    logic signed [PPROD_W-1:0]   pprod_adj;
    logic signed [PQ_W-1:0]      pterm;
    logic signed [TOT_W-1:0]     total;
    logic signed [TOT_W-1:0]     olim_ext;
    logic signed [ERR_W-1:0]     err_abs;
    logic                        in_deadband;
    logic                        out_window;

    // handshake: the output register frees when empty or taken
    assign advance  = !m_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;
    assign s1_fire  = s1_valid_reg && advance;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-DRIVE_W){1'b0}}, drive_reg};

    always_comb begin
        // error and saturating accumulate
        err      = signed'({1'b0, setpoint_reg}) - signed'({1'b0, sample_reg});
        sum_wide = (SUM_WIDTH+1)'(error_sum_reg) + (SUM_WIDTH+1)'(err);
        if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
            // overflow: pick the bound on the side of the true sign
            sum_sat = sum_wide[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                          : {1'b0, {(SUM_WIDTH-1){1'b1}}};
        end else begin
            sum_sat = sum_wide[SUM_WIDTH-1:0];
        end

        // integral term, truncated toward zero, then clamped
        ki_s      = signed'({1'b0, ki_gain_reg});
        iprod     = IPROD_W'(ki_s) * IPROD_W'(sum_sat);
        iprod_adj = iprod + (iprod[IPROD_W-1]
                             ? signed'({{(IPROD_W-FRAC_W){1'b0}}, {FRAC_W{1'b1}}})
                             : signed'({IPROD_W{1'b0}}));
        iq        = iprod_adj[IPROD_W-1:FRAC_W];
        ilim_ext  = signed'({{(IQ_W-LIMIT_W){1'b0}}, integral_limit_reg});
        if (iq > ilim_ext) begin
            iterm = ITERM_W'(ilim_ext);
        end else if (iq < -ilim_ext) begin
            iterm = ITERM_W'(-ilim_ext);
        end else begin
            iterm = iq[ITERM_W-1:0];
        end

        // proportional term, truncated toward zero
        kp_s      = signed'({1'b0, kp_gain_reg});
        pprod     = PPROD_W'(kp_s) * PPROD_W'(err);
        pprod_adj = pprod + (pprod[PPROD_W-1]
                             ? signed'({{(PPROD_W-FRAC_W){1'b0}}, {FRAC_W{1'b1}}})
                             : signed'({PPROD_W{1'b0}}));
        pterm     = pprod_adj[PPROD_W-1:FRAC_W];

        // sum and clamp to the output limit
        total    = TOT_W'(pterm) + TOT_W'(iterm);
        olim_ext = signed'({{(TOT_W-LIMIT_W){1'b0}}, output_limit_reg});
        if (total > olim_ext) begin
            drive_next = DRIVE_W'(olim_ext);
        end else if (total < -olim_ext) begin
            drive_next = DRIVE_W'(-olim_ext);
        end else begin
            drive_next = total[DRIVE_W-1:0];
        end

        // drop the drive outside the valid window
        out_window = (sample_reg < valid_low_reg) || (sample_reg > valid_high_reg);
        if (out_window) begin
            drive_next = '0;
        end

        // clear the accumulator inside the deadband
        err_abs        = err[ERR_W-1] ? -err : err;
        in_deadband    = (err_abs[SAMPLE_W-1:0] <= deadband_reg);
        error_sum_next = in_deadband ? '0 : sum_sat;
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            setpoint_reg       <= RST_SETPOINT;
            kp_gain_reg        <= RST_KP_GAIN;
            ki_gain_reg        <= RST_KI_GAIN;
            integral_limit_reg <= RST_INTEGRAL_LIMIT;
            output_limit_reg   <= RST_OUTPUT_LIMIT;
            deadband_reg       <= RST_DEADBAND;
            valid_low_reg      <= RST_VALID_LOW;
            valid_high_reg     <= RST_VALID_HIGH;
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                REG_SETPOINT:       setpoint_reg       <= cfg_wdata[SAMPLE_W-1:0];
                REG_KP_GAIN:        kp_gain_reg        <= cfg_wdata[GAIN_W-1:0];
                REG_KI_GAIN:        ki_gain_reg        <= cfg_wdata[GAIN_W-1:0];
                REG_INTEGRAL_LIMIT: integral_limit_reg <= cfg_wdata[LIMIT_W-1:0];
                REG_OUTPUT_LIMIT:   output_limit_reg   <= cfg_wdata[LIMIT_W-1:0];
                REG_DEADBAND:       deadband_reg       <= cfg_wdata[SAMPLE_W-1:0];
                REG_VALID_LOW:      valid_low_reg      <= cfg_wdata[SAMPLE_W-1:0];
                REG_VALID_HIGH:     valid_high_reg     <= cfg_wdata[SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

    // control state: valid flags and the accumulator
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            error_sum_reg <= '0;
        end else begin
            if (s_tready) begin
                s1_valid_reg <= s_tvalid;
            end
            if (advance) begin
                m_valid_reg <= s1_valid_reg;
            end
            if (s1_fire) begin
                error_sum_reg <= error_sum_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            sample_reg <= s_tdata[SAMPLE_W-1:0];
        end
        if (s1_fire) begin
            drive_reg <= drive_next;
        end
    end

    // assertions
    `PIPC_ASSERT_NOW(a_ready_only_when_blocked, aclk, aresetn,
        !s_tready, s1_valid_reg && m_valid_reg && !m_tready)
    `PIPC_ASSERT_NEXT(a_sum_holds_when_idle, aclk, aresetn,
        !s1_fire, $stable(error_sum_reg))
    `PIPC_ASSERT_NEXT(a_deadband_clears_sum, aclk, aresetn,
        s1_fire && in_deadband, error_sum_reg == '0)
    `PIPC_ASSERT_NEXT(a_window_zeroes_drive, aclk, aresetn,
        s1_fire && out_window, drive_reg == '0 && m_valid_reg)

endmodule
